>>> hdl/ppbr_pkg.sv
// Package for the point projection bitset rasterizer.
// Holds sizes, opcode, status and state codes, payload and control structs.
// No dependencies.
package ppbr_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int WORD_BITS  = 64;
  localparam int NUM_WORDS  = (MAX_WIDTH * MAX_HEIGHT + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W     = $clog2(NUM_WORDS);
  localparam int BITPOS_W   = $clog2(WORD_BITS);
  localparam int BIT_W      = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int PIX_W      = 10;
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_RE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_IM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_COS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_SIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd6;

  localparam logic [1:0] OP_PLOT  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] ST_PLOTTED = 2'd0;
  localparam logic [1:0] ST_CLIPPED = 2'd1;
  localparam logic [1:0] ST_DUP     = 2'd2;
  localparam logic [1:0] ST_READ    = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ROT0, S_ROT1, S_ROT2, S_X0, S_X1, S_X2,
    S_Y0, S_Y1, S_Y2, S_ADDR, S_READ, S_WRITE, S_CLIP
  } state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] point_re;
    logic signed [31:0] point_im;
    logic [13:0]        word_index;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [63:0] read_word;
    logic [31:0] plotted_count;
    logic [31:0] clipped_count;
    logic [31:0] dedup_count;
  } out_t;

  typedef struct packed {
    logic clr;
    logic load_in;
    logic rot0;
    logic rot1;
    logic rot2;
    logic scale_lo;
    logic scale_hi;
    logic proj;
    logic axis;
    logic addr;
    logic rd;
    logic wr;
    logic clip;
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       proj_ok;
    logic       clr_done;
  } stat_t;

endpackage

>>> hdl/ppbr_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module ppbr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> hdl/ppbr_ctrl.sv
// Controller state machine of the rasterizer.
// Depends on ppbr_pkg.
module ppbr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  ppbr_pkg::stat_t stat_i,
  output ppbr_pkg::cmd_t  cmd_o,
  output logic           busy_o,
  output logic           res_valid_o
);
  import ppbr_pkg::*;

  state_e state_q, state_d;
  logic   valid_q, valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    valid_d = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_ROT0;
        end
      end
      S_ROT0: begin
        cmd_o.rot0 = 1'b1;
        unique case (stat_i.opcode)
          OP_PLOT:           state_d = S_ROT1;
          OP_READ, OP_CLEAR: state_d = S_ADDR;
          default:           state_d = S_IDLE;
        endcase
      end
      S_ROT1: begin
        cmd_o.rot1 = 1'b1;
        state_d = S_ROT2;
      end
      S_ROT2: begin
        cmd_o.rot2 = 1'b1;
        state_d = S_X0;
      end
      S_X0: begin
        cmd_o.scale_lo = 1'b1;
        state_d = S_X1;
      end
      S_X1: begin
        cmd_o.scale_hi = 1'b1;
        state_d = S_X2;
      end
      S_X2: begin
        cmd_o.proj = 1'b1;
        state_d = stat_i.proj_ok ? S_Y0 : S_CLIP;
      end
      S_Y0: begin
        cmd_o.axis = 1'b1;
        cmd_o.scale_lo = 1'b1;
        state_d = S_Y1;
      end
      S_Y1: begin
        cmd_o.axis = 1'b1;
        cmd_o.scale_hi = 1'b1;
        state_d = S_Y2;
      end
      S_Y2: begin
        cmd_o.axis = 1'b1;
        cmd_o.proj = 1'b1;
        state_d = stat_i.proj_ok ? S_ADDR : S_CLIP;
      end
      S_ADDR: begin
        cmd_o.addr = 1'b1;
        state_d = S_READ;
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.wr = 1'b1;
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      S_CLIP: begin
        cmd_o.clip = 1'b1;
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = valid_q;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q) else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted transaction not busy");
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> state_q == S_IDLE) else $error("result strobe outside idle");
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !valid_q) else $error("result during clear pass");
`endif
endmodule

>>> hdl/ppbr_dp.sv
// Datapath of the rasterizer: configuration, projection math, bitset memory.
// Depends on ppbr_pkg and ppbr_ram.
module ppbr_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ppbr_pkg::cmd_t                cmd_i,
  output ppbr_pkg::stat_t               stat_o,
  input  ppbr_pkg::in_t                 in_i,
  input  logic                          cfg_we_i,
  input  logic [ppbr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ppbr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output ppbr_pkg::out_t                res_o
);
  import ppbr_pkg::*;

  logic signed [31:0] center_re_q, center_im_q;
  logic signed [17:0] cos_q, sin_q;
  logic [31:0]        scale_q;
  logic [DIM_W-1:0]   width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_re_q <= '0;
      center_im_q <= '0;
      cos_q       <= 18'sd65536;
      sin_q       <= '0;
      scale_q     <= 32'd6553600;
      width_q     <= DIM_W'(MAX_WIDTH);
      height_q    <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTER_RE: center_re_q <= cfg_data_i;
        REG_CENTER_IM: center_im_q <= cfg_data_i;
        REG_ROT_COS:   cos_q       <= cfg_data_i[17:0];
        REG_ROT_SIN:   sin_q       <= cfg_data_i[17:0];
        REG_SCALE:     scale_q     <= cfg_data_i;
        REG_WIDTH:     width_q     <= cfg_data_i[DIM_W-1:0];
        REG_HEIGHT:    height_q    <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] w_eff, h_eff;
  assign w_eff = (width_q == '0) ? DIM_W'(1) :
                 (width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
  assign h_eff = (height_q == '0) ? DIM_W'(1) :
                 (height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;

  logic [1:0]         op_q;
  logic signed [31:0] pre_q, pim_q;
  logic [13:0]        widx_q;
  logic signed [32:0] dx_q, dy_q;
  logic signed [50:0] p0_q, p1_q;
  logic signed [51:0] rx_q, ry_q;
  logic [63:0]        plo_q;
  logic [51:0]        phi_q;
  logic [PIX_W-1:0]   x_q, y_q;
  logic [ADDR_W-1:0]  addr_q, clr_cnt_q;
  logic [BITPOS_W-1:0] bitpos_q;
  logic [31:0]        plot_cnt_q, clip_cnt_q, dup_cnt_q;
  out_t               res_q;

  logic signed [51:0] r_sel;
  logic [51:0]        mag;
  logic               neg;
  logic [83:0]        total;
  logic [DIM_W-1:0]   ext;
  logic [63:0]        base, tot64, pos;
  logic               ok;
  logic [PIX_W-1:0]   pix;
  logic [BIT_W:0]     bit_idx;
  logic [WORD_BITS-1:0] rdata, mask, wdata;
  logic               hit, ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_addr;

  assign r_sel = cmd_i.axis ? ry_q : rx_q;
  assign mag   = r_sel[51] ? 52'(-r_sel) : 52'(r_sel);
  assign neg   = r_sel[51] ^ cmd_i.axis;
  assign total = {phi_q, 32'b0} + {20'b0, plo_q};
  assign ext   = cmd_i.axis ? h_eff : w_eff;
  assign base  = {6'b0, ext, 47'b0};
  assign tot64 = {2'b0, total[61:0]};
  assign pos   = neg ? base - tot64 : base + tot64;
  assign ok    = !(|total[83:62]) &&
                 (pos[63] ? ((&pos[63:48]) && (|pos[47:0]))
                          : (pos[63:48] < 16'(ext)));
  assign pix   = pos[63] ? '0 : pos[48+PIX_W-1:48];

  assign bit_idx = (BIT_W+1)'(y_q * w_eff) + (BIT_W+1)'(x_q);
  assign mask    = WORD_BITS'(1) << bitpos_q;
  assign hit     = |(rdata & mask);
  assign wdata   = (op_q == OP_PLOT) ? (rdata | mask) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q   <= in_i.opcode;
      pre_q  <= in_i.point_re;
      pim_q  <= in_i.point_im;
      widx_q <= in_i.word_index;
    end
    if (cmd_i.rot0) begin
      dx_q <= 33'(pre_q) - 33'(center_re_q);
      dy_q <= 33'(pim_q) - 33'(center_im_q);
    end
    if (cmd_i.rot1) begin
      p0_q <= dx_q * cos_q;
      p1_q <= dy_q * sin_q;
    end
    if (cmd_i.rot2) begin
      rx_q <= 52'(p0_q) - 52'(p1_q);
      p0_q <= dx_q * sin_q;
      p1_q <= dy_q * cos_q;
    end
    if (cmd_i.scale_lo) begin
      plo_q <= mag[31:0] * scale_q;
      if (!cmd_i.axis) ry_q <= 52'(p0_q) + 52'(p1_q);
    end
    if (cmd_i.scale_hi) phi_q <= 52'(mag[51:32] * scale_q);
    if (cmd_i.proj) begin
      if (cmd_i.axis) y_q <= pix;
      else            x_q <= pix;
    end
    if (cmd_i.addr) begin
      addr_q   <= (op_q == OP_PLOT) ? bit_idx[BIT_W-1:BITPOS_W] : widx_q[ADDR_W-1:0];
      bitpos_q <= bit_idx[BITPOS_W-1:0];
    end
    if (cmd_i.wr) begin
      res_q.read_word <= (op_q == OP_PLOT) ? '0 : rdata;
      res_q.pixel_x   <= (op_q == OP_PLOT) ? x_q : '0;
      res_q.pixel_y   <= (op_q == OP_PLOT) ? y_q : '0;
      res_q.status    <= (op_q != OP_PLOT) ? ST_READ : (hit ? ST_DUP : ST_PLOTTED);
      res_q.plotted_count <= (op_q == OP_PLOT && !hit && ~&plot_cnt_q) ?
                             plot_cnt_q + 32'd1 : plot_cnt_q;
      res_q.dedup_count   <= (op_q == OP_PLOT && hit && ~&dup_cnt_q) ?
                             dup_cnt_q + 32'd1 : dup_cnt_q;
      res_q.clipped_count <= clip_cnt_q;
    end
    if (cmd_i.clip) begin
      res_q.read_word     <= '0;
      res_q.pixel_x       <= '0;
      res_q.pixel_y       <= '0;
      res_q.status        <= ST_CLIPPED;
      res_q.plotted_count <= plot_cnt_q;
      res_q.dedup_count   <= dup_cnt_q;
      res_q.clipped_count <= (~&clip_cnt_q) ? clip_cnt_q + 32'd1 : clip_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      plot_cnt_q <= '0;
      clip_cnt_q <= '0;
      dup_cnt_q  <= '0;
    end else begin
      if (cmd_i.clr) clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      if (cmd_i.wr && op_q == OP_PLOT) begin
        if (hit) begin
          if (~&dup_cnt_q) dup_cnt_q <= dup_cnt_q + 32'd1;
        end else if (~&plot_cnt_q) begin
          plot_cnt_q <= plot_cnt_q + 32'd1;
        end
      end
      if (cmd_i.clip && ~&clip_cnt_q) clip_cnt_q <= clip_cnt_q + 32'd1;
    end
  end

  assign ram_we   = cmd_i.clr || (cmd_i.wr && (op_q == OP_CLEAR || (op_q == OP_PLOT && !hit)));
  assign ram_re   = cmd_i.rd;
  assign ram_addr = cmd_i.clr ? clr_cnt_q : addr_q;

  ppbr_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(NUM_WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(cmd_i.clr ? '0 : wdata),
    .rdata_o(rdata)
  );

  assign stat_o.opcode   = op_q;
  assign stat_o.proj_ok  = ok;
  assign stat_o.clr_done = (clr_cnt_q == ADDR_W'(NUM_WORDS - 1));
  assign res_o = res_q;
endmodule

>>> hdl/point_projection_bitset_rasterizer.sv
// Point projection bitset rasterizer, top level: controller plus datapath.
// A plot is rotated, projected on x then y (a clip on either ends it early) and then
// read-modify-written; OP_READ and OP_CLEAR skip projection; OP_NONE gives no result.
// Throughput: one transaction at a time, set by the shared scale multiplier and
// the bitset read-modify-write; a new start is taken in the strobe cycle.
// After reset a clearing pass zeroes the 16384-word bitset, with busy_o high throughout.
module point_projection_bitset_rasterizer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  ppbr_pkg::in_t                   in_i,
  input  logic                            cfg_we_i,
  input  logic [ppbr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ppbr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            res_valid_o,
  output ppbr_pkg::out_t                  res_o
);
  import ppbr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ppbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o)
  );

  ppbr_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .in_i      (in_i),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .res_o     (res_o)
  );
endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for point_projection_bitset_rasterizer.
// Drives plot/read/clear transactions with bursty starts, predicts each result in a
// local model of the projection and bitset, and compares every field. Needs ppbr_pkg.
module testbench;
  import ppbr_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  in_t in_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic res_valid_o;
  out_t res_o;

  point_projection_bitset_rasterizer dut (.*);

  initial forever #1 clk_i = ~clk_i;

  // predictor state
  logic [63:0] bits_m [NUM_WORDS];
  logic [31:0] n_plot, n_clip, n_dup;
  logic signed [31:0] c_re, c_im;
  logic signed [17:0] r_cos, r_sin;
  logic [31:0] v_scale;
  logic [10:0] img_w, img_h;

  in_t pending_q[$];
  out_t expected_q[$];
  int errors = 0;

  function automatic logic [31:0] sat_inc(logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function automatic int unsigned dim_clamp(logic [10:0] v, int unsigned m);
    if (v == 0) return 1;
    if (v > m) return m;
    return v;
  endfunction

  function automatic bit axis_pixel(longint r, logic [31:0] sc, int unsigned ext,
                                    bit negate, output int unsigned pix);
    bit neg;
    logic [63:0] mag, p_lo, p_hi, total;
    longint base, pos;
    neg = (r < 0) != negate;
    mag = (r < 0) ? -r : r;
    p_lo = {32'd0, mag[31:0]} * {32'd0, sc};
    p_hi = {32'd0, mag[63:32]} * {32'd0, sc};
    pix = 0;
    if (p_hi >= 64'd1 << 30) return 0;
    total = (p_hi << 32) + p_lo;
    if (total < p_lo || total >= 64'd1 << 62) return 0;
    base = longint'(ext) <<< 47;
    pos = neg ? base - longint'(total) : base + longint'(total);
    if (pos >= 0) begin
      pix = int'(pos >>> 48);
      return pix < ext;
    end
    return pos > -(longint'(1) <<< 48);
  endfunction

  function automatic out_t raster_predict(in_t t);
    out_t o;
    longint dx, dy, rx, ry;
    int unsigned w, h, x, y, b;
    bit okx, oky;
    o = '0;
    if (t.opcode == OP_PLOT) begin
      dx = longint'(t.point_re) - longint'(c_re);
      dy = longint'(t.point_im) - longint'(c_im);
      rx = dx * longint'(r_cos) - dy * longint'(r_sin);
      ry = dx * longint'(r_sin) + dy * longint'(r_cos);
      w = dim_clamp(img_w, MAX_WIDTH);
      h = dim_clamp(img_h, MAX_HEIGHT);
      okx = axis_pixel(rx, v_scale, w, 0, x);
      oky = okx && axis_pixel(ry, v_scale, h, 1, y);
      if (!oky) begin
        o.status = ST_CLIPPED;
        n_clip = sat_inc(n_clip);
      end else begin
        b = y * w + x;
        o.pixel_x = 10'(x);
        o.pixel_y = 10'(y);
        if (bits_m[b / 64][b % 64]) begin
          o.status = ST_DUP;
          n_dup = sat_inc(n_dup);
        end else begin
          bits_m[b / 64][b % 64] = 1'b1;
          o.status = ST_PLOTTED;
          n_plot = sat_inc(n_plot);
        end
      end
    end else begin
      o.status = ST_READ;
      o.read_word = bits_m[t.word_index];
      if (t.opcode == OP_CLEAR) bits_m[t.word_index] = '0;
    end
    o.plotted_count = n_plot;
    o.clipped_count = n_clip;
    o.dedup_count = n_dup;
    return o;
  endfunction

  // driver: busy_o is stable from the falling edge to the next rising edge,
  // so a start driven while busy_o is low is taken at that rising edge
  int gap = 0, burst = 0;
  always @(negedge clk_i) begin
    if (!rst_ni || busy_o) begin
      start_i <= 1'b0;
    end else if (gap > 0) begin
      gap <= gap - 1;
      start_i <= 1'b0;
    end else if (pending_q.size() > 0) begin
      start_i <= 1'b1;
      in_i <= pending_q[0];
      if (pending_q[0].opcode != OP_NONE)
        expected_q.push_back(raster_predict(pending_q[0]));
      void'(pending_q.pop_front());
      if (burst > 0) begin
        burst <= burst - 1;
      end else begin
        burst <= $urandom_range(0, 12);
        gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end
    end else begin
      start_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: status %0d", res_o.status);
        errors++;
      end else begin
        out_t e;
        e = expected_q.pop_front();
        if (e.status != res_o.status) begin
          $error("status exp %0d got %0d", e.status, res_o.status); errors++; end
        if (e.pixel_x != res_o.pixel_x) begin
          $error("pixel_x exp %0d got %0d", e.pixel_x, res_o.pixel_x); errors++; end
        if (e.pixel_y != res_o.pixel_y) begin
          $error("pixel_y exp %0d got %0d", e.pixel_y, res_o.pixel_y); errors++; end
        if (e.read_word != res_o.read_word) begin
          $error("read_word exp %h got %h", e.read_word, res_o.read_word); errors++; end
        if (e.plotted_count != res_o.plotted_count) begin
          $error("plotted_count exp %0d got %0d", e.plotted_count, res_o.plotted_count);
          errors++;
        end
        if (e.clipped_count != res_o.clipped_count) begin
          $error("clipped_count exp %0d got %0d", e.clipped_count, res_o.clipped_count);
          errors++;
        end
        if (e.dedup_count != res_o.dedup_count) begin
          $error("dedup_count exp %0d got %0d", e.dedup_count, res_o.dedup_count);
          errors++;
        end
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_CENTER_RE: c_re = val;
      REG_CENTER_IM: c_im = val;
      REG_ROT_COS:   r_cos = val[17:0];
      REG_ROT_SIN:   r_sin = val[17:0];
      REG_SCALE:     v_scale = val;
      REG_WIDTH:     img_w = val[10:0];
      default:       img_h = val[10:0];
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || start_i || expected_q.size() > 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic in_t plot_item(logic signed [31:0] re, logic signed [31:0] im);
    in_t t;
    t = '0;
    t.opcode = OP_PLOT;
    t.point_re = re;
    t.point_im = im;
    t.word_index = 14'($urandom);
    return t;
  endfunction

  function automatic in_t read_item(logic [1:0] op, logic [13:0] idx);
    in_t t;
    t.opcode = op;
    t.point_re = $urandom;
    t.point_im = $urandom;
    t.word_index = idx;
    return t;
  endfunction

  // a point near the frame in the current view, in Q16.16 around the center
  function automatic in_t near_point();
    int span;
    span = $urandom_range(0, 3) == 0 ? 32'h7FFF_FFFF : (1 << $urandom_range(10, 24));
    return plot_item(c_re + $signed($urandom_range(0, 2 * span) - span),
                     c_im + $signed($urandom_range(0, 2 * span) - span));
  endfunction

  function automatic logic [13:0] rand_index();
    return 14'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 600));
  endfunction

  function automatic in_t random_item();
    int k;
    k = $urandom_range(0, 19);
    if (k < 13) return near_point();
    if (k < 14) return plot_item($urandom, $urandom);
    if (k < 16) return read_item(OP_READ, rand_index());
    if (k < 18) return read_item(OP_CLEAR, rand_index());
    return read_item(OP_NONE, 14'($urandom));
  endfunction

  initial begin
    for (int i = 0; i < NUM_WORDS; i++) bits_m[i] = '0;
    n_plot = 0; n_clip = 0; n_dup = 0;
    c_re = 0; c_im = 0; r_cos = 65536; r_sin = 0; v_scale = 6553600;
    img_w = 1024; img_h = 1024;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: defaults
    pending_q.push_back(plot_item(0, 0));
    pending_q.push_back(plot_item(0, 0));
    pending_q.push_back(plot_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    pending_q.push_back(plot_item(32'sh8000_0000, 32'sh8000_0000));
    pending_q.push_back(plot_item(-32'sd335545, 32'sd335544));
    pending_q.push_back(plot_item(32'sd335544, -32'sd335545));
    pending_q.push_back(plot_item(-32'sd335544, 32'sd335544));
    pending_q.push_back(read_item(OP_READ, 14'd8192));
    pending_q.push_back(read_item(OP_NONE, 14'd8192));
    pending_q.push_back(read_item(OP_CLEAR, 14'd8192));
    pending_q.push_back(read_item(OP_READ, 14'd8192));
    pending_q.push_back(read_item(OP_READ, 14'h3FFF));
    pending_q.push_back(read_item(OP_CLEAR, 14'd0));
    drain();
    // directed: odd frame sizes, huge scale, rotation
    cfg_write(REG_WIDTH, 0);
    cfg_write(REG_HEIGHT, 32'h7FF);
    cfg_write(REG_SCALE, 32'hFFFF_FFFF);
    cfg_write(REG_ROT_COS, -65536);
    cfg_write(REG_ROT_SIN, 65536);
    cfg_write(REG_CENTER_RE, 32'h8000_0000);
    cfg_write(REG_CENTER_IM, 32'h7FFF_FFFF);
    pending_q.push_back(plot_item(32'h8000_0000, 32'h7FFF_FFFF));
    pending_q.push_back(plot_item(32'h8000_0001, 32'h7FFF_FFFF));
    pending_q.push_back(plot_item(32'h7FFF_FFFF, 32'h8000_0000));
    pending_q.push_back(plot_item(32'h8000_0000, 32'h7FFF_FFFE));
    pending_q.push_back(read_item(OP_READ, 14'd0));
    drain();
    // random phases with varied settings
    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(REG_CENTER_RE, (ph == 7) ? 32'h8000_0000 :
                               $urandom_range(0, 1 << 18) - (1 << 17));
      cfg_write(REG_CENTER_IM, (ph == 7) ? 32'h7FFF_FFFF :
                               $urandom_range(0, 1 << 18) - (1 << 17));
      cfg_write(REG_ROT_COS, (ph == 0) ? 65536 : (ph == 1) ? -65536 :
                             $urandom_range(0, 131072) - 65536);
      cfg_write(REG_ROT_SIN, (ph == 2) ? -65536 : (ph == 3) ? 65536 :
                             $urandom_range(0, 131072) - 65536);
      cfg_write(REG_SCALE, (ph == 4) ? 0 : (ph == 5) ? 32'hFFFF_FFFF :
                           $urandom_range(1 << 16, 1 << 24));
      cfg_write(REG_WIDTH, (ph == 6) ? 1 : (ph == 1) ? 1024 : $urandom_range(1, 64));
      cfg_write(REG_HEIGHT, (ph == 6) ? 1024 : (ph == 1) ? 1 : $urandom_range(1, 64));
      for (int i = 0; i < 140; i++) pending_q.push_back(random_item());
      drain();
    end
    if (errors == 0)
      $display("point_projection_bitset_rasterizer regression: pass");
    else
      $display("point_projection_bitset_rasterizer regression: fail");
    $finish;
  end

  initial begin
    #400000;
    $display("point_projection_bitset_rasterizer regression: fail");
    $finish;
  end
endmodule
